/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/vdm_pkg.sv */
// ----------------------------------------------------------------------------
// vdm_pkg
// Types and constants of the vector distance metric block.
// ----------------------------------------------------------------------------
package vdm_pkg;

  // Field and datapath widths
  localparam int unsigned FeatW = 16;  // feature element width
  localparam int unsigned DiffW = 17;  // signed difference of two features
  localparam int unsigned AbsW  = 16;  // magnitude of the difference
  localparam int unsigned TermW = 32;  // squared magnitude
  localparam int unsigned SumW  = 41;  // running accumulator
  localparam int unsigned AluW  = 42;  // shared adder, top bit is carry/borrow
  localparam int unsigned DistW = 24;  // result field

  localparam logic [SumW-1:0]  SumMax  = {SumW{1'b1}};
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  // Metric register codes
  typedef enum logic [1:0] {
    METRIC_EUCLID    = 2'd0,
    METRIC_CITY      = 2'd1,
    METRIC_DIFFCOUNT = 2'd2,
    METRIC_MAXDIFF   = 2'd3
  } metric_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_ABS,
    S_SQR,
    S_FOLD,
    S_ROOT,
    S_EMIT
  } vdm_state_e;

endpackage

/* hdl/vector_distance_metric.sv */
// ----------------------------------------------------------------------------
// vector_distance_metric
// Streaming distance between two feature vectors, one element pair per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one element pair per item
//   with last_pair_i set on the final pair of the vectors. Output channel
//   (out_valid_o / out_stall_i) carries one distance per vector pair. The
//   metric is written through cfg_valid_i / cfg_ready_o / cfg_data_i; ready
//   is high only while idle with no item offered.
// Datapath:
//   Difference, magnitude, fold and root share one 42-bit add/subtract unit
//   under a small sequencer; the square is one 16x16 multiply. A non-last
//   pair passes the difference, magnitude, square and fold steps before the
//   block goes idle and accepts the next pair. A last pair adds an emit
//   step, and in Euclidean mode a bit-pair square-root loop on the same adder
//   before it. The emit step loads the distance into the output register.
// Reset:
//   Clears the accumulator, the metric register (Euclidean) and the output
//   valid flag.
// Stall:
//   A valid distance holds in the output register while out_stall_i is high;
//   the next item may be accepted and folded meanwhile, and its result waits
//   in the emit step until the register frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vector_distance_metric (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_data_i,
  // element pair input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [vdm_pkg::FeatW-1:0] first_value_i,
  input  logic signed [vdm_pkg::FeatW-1:0] second_value_i,
  input  logic                            last_pair_i,
  // distance output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [vdm_pkg::DistW-1:0]       distance_o
);

  // Control state
  vdm_pkg::vdm_state_e state_q, state_d;
  vdm_pkg::metric_e    mode_q;
  logic                out_valid_q, out_valid_d;
  logic [vdm_pkg::SumW-1:0] sum_q, sum_d;

  // Datapath registers
  logic signed [vdm_pkg::FeatW-1:0] a_q, b_q;
  logic                             last_q;
  logic signed [vdm_pkg::DiffW-1:0] diff_q, diff_d;
  logic [vdm_pkg::AbsW-1:0]         ad_q, ad_d;
  logic [vdm_pkg::TermW-1:0]        term_q, term_d;
  logic [vdm_pkg::SumW-1:0]         root_q, root_d;
  logic [vdm_pkg::SumW-1:0]         bit_q, bit_d;
  logic [vdm_pkg::DistW-1:0]        res_q, res_d;
  logic [vdm_pkg::DistW-1:0]        dist_q;

  // Shared add/subtract unit
  logic [vdm_pkg::AluW-1:0] alu_a, alu_b, alu_res;
  logic                     alu_sub;

  logic in_fire;
  logic emit_fire;
  logic [vdm_pkg::SumW-1:0] fold_sum;

  assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  assign in_stall_o  = (state_q != vdm_pkg::S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign emit_fire   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = (state_q == vdm_pkg::S_IDLE) && !in_valid_i;
  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vdm_pkg::S_IDLE: if (in_fire) state_d = vdm_pkg::S_DIFF;
      vdm_pkg::S_DIFF: state_d = vdm_pkg::S_ABS;
      vdm_pkg::S_ABS:  state_d = vdm_pkg::S_SQR;
      vdm_pkg::S_SQR:  state_d = vdm_pkg::S_FOLD;
      vdm_pkg::S_FOLD: begin
        if (!last_q) begin
          state_d = vdm_pkg::S_IDLE;
        end else if (mode_q == vdm_pkg::METRIC_EUCLID) begin
          state_d = vdm_pkg::S_ROOT;
        end else begin
          state_d = vdm_pkg::S_EMIT;
        end
      end
      vdm_pkg::S_ROOT: if (bit_q[0]) state_d = vdm_pkg::S_EMIT;
      vdm_pkg::S_EMIT: if (emit_fire) state_d = vdm_pkg::S_IDLE;
      default:         state_d = vdm_pkg::S_IDLE;
    endcase
  end

  // Datapath control: drive the shared unit and the next register values
  always_comb begin
    alu_a    = '0;
    alu_b    = '0;
    alu_sub  = 1'b0;
    sum_d    = sum_q;
    diff_d   = diff_q;
    ad_d     = ad_q;
    term_d   = term_q;
    root_d   = root_q;
    bit_d    = bit_q;
    res_d    = res_q;
    fold_sum = sum_q;
    unique case (state_q)
      vdm_pkg::S_DIFF: begin
        // signed difference of the two features
        alu_a   = {{(vdm_pkg::AluW-vdm_pkg::FeatW){a_q[vdm_pkg::FeatW-1]}}, a_q};
        alu_b   = {{(vdm_pkg::AluW-vdm_pkg::FeatW){b_q[vdm_pkg::FeatW-1]}}, b_q};
        alu_sub = 1'b1;
        diff_d  = alu_res[vdm_pkg::DiffW-1:0];
      end
      vdm_pkg::S_ABS: begin
        // magnitude: negate a negative difference
        if (diff_q[vdm_pkg::DiffW-1]) begin
          alu_b   = {{(vdm_pkg::AluW-vdm_pkg::DiffW){1'b1}}, diff_q};
          alu_sub = 1'b1;
        end else begin
          alu_a   = {{(vdm_pkg::AluW-vdm_pkg::DiffW){1'b0}}, diff_q};
        end
        ad_d = alu_res[vdm_pkg::AbsW-1:0];
      end
      vdm_pkg::S_SQR: begin
        // per-metric term of this pair
        unique case (mode_q)
          vdm_pkg::METRIC_EUCLID:    term_d = ad_q * ad_q;
          vdm_pkg::METRIC_DIFFCOUNT: term_d = vdm_pkg::TermW'(ad_q != '0);
          default:                   term_d = vdm_pkg::TermW'(ad_q);
        endcase
      end
      vdm_pkg::S_FOLD: begin
        alu_a = {1'b0, sum_q};
        alu_b = vdm_pkg::AluW'(term_q);
        if (mode_q == vdm_pkg::METRIC_MAXDIFF) begin
          // keep the larger of the running maximum and the new magnitude
          alu_sub  = 1'b1;
          fold_sum = alu_res[vdm_pkg::AluW-1] ? vdm_pkg::SumW'(term_q) : sum_q;
        end else begin
          // saturating accumulate
          fold_sum = alu_res[vdm_pkg::AluW-1] ? vdm_pkg::SumMax
                                              : alu_res[vdm_pkg::SumW-1:0];
        end
        sum_d = fold_sum;
        if (last_q) begin
          if (mode_q == vdm_pkg::METRIC_EUCLID) begin
            // start the root loop on the finished sum
            root_d = '0;
            bit_d  = {1'b1, {(vdm_pkg::SumW-1){1'b0}}};
          end else begin
            res_d = (|fold_sum[vdm_pkg::SumW-1:vdm_pkg::DistW]) ? vdm_pkg::DistMax
                                                              : fold_sum[vdm_pkg::DistW-1:0];
            sum_d = '0;
          end
        end
      end
      vdm_pkg::S_ROOT: begin
        // one bit-pair step of the floor square root, remainder kept in sum_q
        alu_a   = {1'b0, sum_q};
        alu_b   = {1'b0, root_q | bit_q};
        alu_sub = 1'b1;
        if (!alu_res[vdm_pkg::AluW-1]) begin
          sum_d  = alu_res[vdm_pkg::SumW-1:0];
          root_d = (root_q >> 1) | bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          res_d = root_d[vdm_pkg::DistW-1:0];
          sum_d = '0;
        end
      end
      default: ;
    endcase
  end

  // Output register: load on emit, drop once taken
  assign out_valid_d = ((state_q == vdm_pkg::S_EMIT) && emit_fire) ||
                       (out_valid_q && out_stall_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vdm_pkg::S_IDLE;
      mode_q      <= vdm_pkg::METRIC_EUCLID;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= vdm_pkg::metric_e'(cfg_data_i);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q    <= first_value_i;
      b_q    <= second_value_i;
      last_q <= last_pair_i;
    end
    diff_q <= diff_d;
    ad_q   <= ad_d;
    term_q <= term_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    res_q  <= res_d;
    if ((state_q == vdm_pkg::S_EMIT) && emit_fire) begin
      dist_q <= res_q;
    end
  end

  // Checks
  `ASSERT_IMPL(a_root_bit_onehot, clk_i, rst_ni, state_q == vdm_pkg::S_ROOT,
               $onehot(bit_q), "root step bit is not one-hot")
  `ASSERT_IMPL(a_sum_cleared_at_emit, clk_i, rst_ni, state_q == vdm_pkg::S_EMIT,
               sum_q == '0, "accumulator not cleared before emit")
  `ASSERT_NEXT(a_emit_loads_output, clk_i, rst_ni,
               (state_q == vdm_pkg::S_EMIT) && !(out_valid_q && out_stall_i),
               out_valid_q && (state_q == vdm_pkg::S_IDLE), "emit did not load output")

endmodule

/* tb/sv/tb_vector_distance_metric.sv */
// ----------------------------------------------------------------------------
// tb_vector_distance_metric
// Self-checking bench for the streaming vector distance block.
// ----------------------------------------------------------------------------
// Element pairs go in through the input channel while a local model folds each
// accepted pair into its own accumulator and queues the distance of every
// finished vector. A checker compares each distance taken from the output
// channel with the oldest queued one. Covered: all four metrics at the
// feature extremes, a metric change inside a vector, output saturation,
// a long receiver hold, and random vectors with random gaps.
// ----------------------------------------------------------------------------
module tb_vector_distance_metric;

  localparam int unsigned SettleCycles = 40;    // fold plus emit plus root loop
  localparam int unsigned HoldCycles   = 300;   // long receiver hold-off
  localparam int unsigned StuckLimit   = 2000;  // cycles without any handshake
  localparam int unsigned RandomPairs  = 100;

  logic                             clk_i          = 1'b0;
  logic                             rst_ni         = 1'b0;
  logic                             cfg_valid_i    = 1'b0;
  logic                             cfg_ready_o;
  logic [1:0]                       cfg_data_i     = '0;
  logic                             in_valid_i     = 1'b0;
  logic                             in_stall_o;
  logic signed [vdm_pkg::FeatW-1:0] first_value_i  = '0;
  logic signed [vdm_pkg::FeatW-1:0] second_value_i = '0;
  logic                             last_pair_i    = 1'b0;
  logic                             out_valid_o;
  logic                             out_stall_i    = 1'b0;
  logic [vdm_pkg::DistW-1:0]        distance_o;

  // Model state
  logic [vdm_pkg::SumW-1:0]  acc_sum    = '0;
  vdm_pkg::metric_e          cur_metric = vdm_pkg::METRIC_EUCLID;
  logic [vdm_pkg::DistW-1:0] pending_distances[$];

  // Bench control and tallies
  bit          gaps_on      = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned mismatches   = 0;
  int unsigned pairs_sent   = 0;
  int unsigned dists_seen   = 0;
  int unsigned metric_writes = 0;
  int unsigned quiet_cycles = 0;

  vector_distance_metric i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .last_pair_i    (last_pair_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .distance_o     (distance_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Model of the datapath
  // --------------------------------------------------------------------------

  // Add with clamp at the accumulator ceiling
  function automatic logic [vdm_pkg::SumW-1:0] add_clamped(
      input logic [vdm_pkg::SumW-1:0] acc,
      input logic [vdm_pkg::SumW-1:0] x);
    logic [vdm_pkg::SumW:0] total;
    total = {1'b0, acc} + {1'b0, x};
    return total[vdm_pkg::SumW] ? vdm_pkg::SumMax : total[vdm_pkg::SumW-1:0];
  endfunction

  // Floor square root, one result bit per step from the top
  function automatic logic [vdm_pkg::DistW-1:0] floor_root(
      input logic [vdm_pkg::SumW-1:0] n);
    logic [20:0] root;
    logic [21:0] trial;
    logic [43:0] trial_sq;
    root = '0;
    for (int i = 20; i >= 0; i--) begin
      trial    = {1'b0, root} | (22'd1 << i);
      trial_sq = trial * trial;
      if (trial_sq <= {3'b0, n}) root = trial[20:0];
    end
    return vdm_pkg::DistW'(root);
  endfunction

  // Fold one accepted pair; queue the distance when the vector ends
  function automatic void fold_pair(input logic signed [vdm_pkg::FeatW-1:0] a,
                                    input logic signed [vdm_pkg::FeatW-1:0] b,
                                    input logic last_flag);
    logic [vdm_pkg::DiffW-1:0] diff;
    logic [vdm_pkg::DiffW-1:0] mag;
    logic [33:0]               sq;
    logic [vdm_pkg::SumW-1:0]  value;
    diff = {a[vdm_pkg::FeatW-1], a} - {b[vdm_pkg::FeatW-1], b};
    mag  = diff[vdm_pkg::DiffW-1] ? (~diff + 1'b1) : diff;
    sq   = mag * mag;
    case (cur_metric)
      vdm_pkg::METRIC_EUCLID:
        acc_sum = add_clamped(acc_sum, vdm_pkg::SumW'(sq));
      vdm_pkg::METRIC_CITY:
        acc_sum = add_clamped(acc_sum, vdm_pkg::SumW'(mag));
      vdm_pkg::METRIC_DIFFCOUNT:
        if (mag != '0) acc_sum = add_clamped(acc_sum, vdm_pkg::SumW'(1));
      default:
        if (vdm_pkg::SumW'(mag) > acc_sum) acc_sum = vdm_pkg::SumW'(mag);
    endcase
    if (last_flag) begin
      value = (cur_metric == vdm_pkg::METRIC_EUCLID) ?
              vdm_pkg::SumW'(floor_root(acc_sum)) : acc_sum;
      pending_distances.push_back((value > vdm_pkg::SumW'(vdm_pkg::DistMax)) ?
                                  vdm_pkg::DistMax : value[vdm_pkg::DistW-1:0]);
      acc_sum = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one element pair after a random gap, if gaps are on, and hold it until accepted
  task automatic send_pair(input logic signed [vdm_pkg::FeatW-1:0] a,
                           input logic signed [vdm_pkg::FeatW-1:0] b,
                           input logic last_flag);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    first_value_i  <= a;
    second_value_i <= b;
    last_pair_i    <= last_flag;
    do @(posedge clk_i); while (in_stall_o);
    fold_pair(a, b, last_flag);
    pairs_sent++;
  endtask

  // Drop the input valid after the last pair of a phase
  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  // Write the metric register and mirror it in the model
  task automatic write_metric(input vdm_pkg::metric_e m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_metric = m;
    metric_writes++;
  endtask

  // Wait until every queued distance is out and the block has gone quiet
  task automatic wait_idle();
    while (pending_distances.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Pick a feature value that favors extremes and small magnitudes
  function automatic logic signed [vdm_pkg::FeatW-1:0] draw_feature();
    case ($urandom_range(0, 5))
      0:       return 16'sh7FFF;
      1:       return -16'sh8000;
      2:       return 16'(int'($urandom_range(0, 8)) - 4);
      3:       return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one vector of random content
  task automatic send_vector(input int unsigned len);
    logic signed [vdm_pkg::FeatW-1:0] a;
    logic signed [vdm_pkg::FeatW-1:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      a = draw_feature();
      b = ($urandom_range(0, 4) == 0) ? a : draw_feature();
      send_pair(a, b, i == len - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------

  // Stall the output at random, with one long hold on request
  initial begin
    int unsigned gap;
    @(posedge clk_i iff rst_ni);
    forever begin
      gap = gaps_on ? $urandom_range(0, 9) : 0;
      if (hold_request) begin
        gap = HoldCycles;
        hold_request = 1'b0;
      end
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic report(input string what, input logic [vdm_pkg::DistW-1:0] got,
                        input logic [vdm_pkg::DistW-1:0] want);
    $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Compare each accepted distance with the oldest prediction
  always @(posedge clk_i) begin
    logic [vdm_pkg::DistW-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      dists_seen++;
      if (pending_distances.size() == 0) begin
        report("distance with none pending", distance_o, '0);
      end else begin
        want = pending_distances.pop_front();
        if (distance_o !== want) report("distance mismatch", distance_o, want);
      end
    end
  end

  // End the run when no handshake happens for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StuckLimit) begin
        $display("timeout: no handshake for %0d cycles", StuckLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every metric on extreme, equal and zero features, short vectors
  task automatic test_extremes();
    vdm_pkg::metric_e m;
    for (int i = 3; i >= 0; i--) begin
      m = vdm_pkg::metric_e'(i);
      wait_idle();
      write_metric(m);
      send_pair(16'sh7FFF, -16'sh8000, 1'b0);
      send_pair(-16'sh8000, 16'sh7FFF, 1'b0);
      send_pair(-16'sh1, -16'sh1, 1'b0);
      send_pair(16'sh1, -16'sh1, 1'b1);
      send_pair('0, '0, 1'b1);
      stop_sending();
    end
  endtask

  // Change the metric halfway through a vector
  task automatic test_metric_switch();
    wait_idle();
    write_metric(vdm_pkg::METRIC_CITY);
    send_pair(16'sh0100, -16'sh0100, 1'b0);
    send_pair(16'sh0003, 16'sh0007, 1'b0);
    stop_sending();
    wait_idle();
    write_metric(vdm_pkg::METRIC_MAXDIFF);
    send_pair(16'sh0010, 16'sh0000, 1'b0);
    send_pair(-16'sh0002, 16'sh0002, 1'b1);
    stop_sending();
  endtask

  // Drive the output into saturation
  task automatic test_saturation();
    wait_idle();
    gaps_on = 1'b0;
    write_metric(vdm_pkg::METRIC_CITY);
    for (int i = 0; i < 260; i++) send_pair(16'sh7FFF, -16'sh8000, i == 259);
    stop_sending();
    gaps_on = 1'b1;
  endtask

  // Hold the output for a long time while short vectors keep coming
  task automatic test_backpressure();
    wait_idle();
    write_metric(vdm_pkg::METRIC_DIFFCOUNT);
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++) send_vector($urandom_range(1, 2));
    stop_sending();
    gaps_on = 1'b1;
  endtask

  // Random metrics, vector lengths, contents and gaps
  task automatic test_random();
    int unsigned start;
    int unsigned len;
    start = pairs_sent;
    while (pairs_sent - start < RandomPairs) begin
      wait_idle();
      gaps_on = ($urandom_range(0, 3) != 0);
      write_metric(vdm_pkg::metric_e'($urandom_range(0, 3)));
      repeat ($urandom_range(2, 6)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        send_vector(len);
      end
      stop_sending();
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_metric_switch();
    test_saturation();
    test_backpressure();
    test_random();
    wait_idle();

    $display("covered %0d element pairs and %0d distances over %0d metric writes,",
             pairs_sent, dists_seen, metric_writes);
    $display("including mid-vector metric change, saturation and a long output hold");
    if (mismatches == 0 && pending_distances.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d distances never seen", mismatches,
               pending_distances.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* vector_distance_metric.f */
+incdir+hdl
hdl/vdm_pkg.sv
hdl/vector_distance_metric.sv
tb/sv/tb_vector_distance_metric.sv
